[design/mrt_pkg.sv]
// Shared types and constants for the multi-rate tick flag timer.
`timescale 1ns / 1ps
package mrt_pkg;

  localparam int NUM_CNT   = 6;
  localparam int CNT_W     = 16;
  localparam int TIME_W    = 32;
  localparam int FLAG_W    = NUM_CNT + 1;
  localparam int EVENT_W   = NUM_CNT - 1;
  localparam int CFG_IDX_W = 3;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] period_t;

  // Reload values after reset, fastest counter in the lowest slot.
  localparam period_t PERIOD_RESET = {16'd60000, 16'd10000, 16'd1000,
                                      16'd100, 16'd10, 16'd5};

  typedef enum logic [1:0] {
    OP_UPDATE     = 2'd0,
    OP_CLEAR_MASK = 2'd1,
    OP_CLEAR_ALL  = 2'd2,
    OP_START      = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_5MS    = 3'd0,
    REG_PERIOD_10MS   = 3'd1,
    REG_PERIOD_100MS  = 3'd2,
    REG_PERIOD_1S     = 3'd3,
    REG_PERIOD_10S    = 3'd4,
    REG_PERIOD_1MIN   = 3'd5,
    REG_EVENT_ENABLE  = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] now_ms;
    logic [FLAG_W-1:0] clear_mask;
  } item_t;

  typedef struct packed {
    logic [FLAG_W-1:0]  flags;
    logic [EVENT_W-1:0] events;
  } result_t;

endpackage

[design/mrt_cfg.sv]
// Configuration register file: reload periods and event enables.
`timescale 1ns / 1ps
module mrt_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrt_pkg::CNT_W-1:0]     cfg_data,
  output mrt_pkg::period_t              period,
  output logic [mrt_pkg::EVENT_W-1:0]   event_enable
);
  import mrt_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period       <= PERIOD_RESET;
      event_enable <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PERIOD_5MS:   period[0] <= cfg_data;
        REG_PERIOD_10MS:  period[1] <= cfg_data;
        REG_PERIOD_100MS: period[2] <= cfg_data;
        REG_PERIOD_1S:    period[3] <= cfg_data;
        REG_PERIOD_10S:   period[4] <= cfg_data;
        REG_PERIOD_1MIN:  period[5] <= cfg_data;
        REG_EVENT_ENABLE: event_enable <= cfg_data[EVENT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[design/mrt_core.sv]
// Timer state and combinational step logic: elapsed time, counters, sticky flags.
`timescale 1ns / 1ps
module mrt_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  mrt_pkg::item_t              item,
  input  mrt_pkg::period_t            period,
  input  logic [mrt_pkg::EVENT_W-1:0] event_enable,
  output mrt_pkg::result_t            result
);
  import mrt_pkg::*;

  logic [TIME_W-1:0]  last_time, last_time_next;
  period_t            remaining, remaining_next;
  logic [FLAG_W-1:0]  sticky_flags, sticky_flags_next;
  logic [TIME_W-1:0]  elapsed;
  period_t            dec;
  logic [NUM_CNT-1:0] fire;

  always_comb begin
    elapsed           = item.now_ms - last_time;
    last_time_next    = last_time;
    remaining_next    = remaining;
    sticky_flags_next = sticky_flags;
    fire              = '0;
    dec               = '0;
    for (int i = 0; i < NUM_CNT; i++) begin
      // clamp at zero when the gap exceeds the remaining count
      if (elapsed > {{(TIME_W-CNT_W){1'b0}}, remaining[i]}) begin
        dec[i] = '0;
      end else begin
        dec[i] = remaining[i] - elapsed[CNT_W-1:0];
      end
    end
    case (item.op)
      OP_UPDATE: begin
        if (elapsed != '0) begin
          sticky_flags_next[0] = 1'b1;
        end
        for (int i = 0; i < NUM_CNT; i++) begin
          fire[i] = (dec[i] == '0);
          if (fire[i]) begin
            remaining_next[i]        = period[i];
            sticky_flags_next[i + 1] = 1'b1;
          end else begin
            remaining_next[i] = dec[i];
          end
        end
        last_time_next = item.now_ms;
      end
      OP_CLEAR_MASK: sticky_flags_next = sticky_flags & ~item.clear_mask;
      OP_CLEAR_ALL: begin
        sticky_flags_next = '0;
        remaining_next    = period;
      end
      OP_START: last_time_next = item.now_ms;
      default: ;
    endcase
    result.flags  = sticky_flags_next;
    // the fastest counter has no event bit
    result.events = fire[NUM_CNT-1:1] & event_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time    <= '0;
      remaining    <= PERIOD_RESET;
      sticky_flags <= '0;
    end else if (advance) begin
      last_time    <= last_time_next;
      remaining    <= remaining_next;
      sticky_flags <= sticky_flags_next;
    end
  end

endmodule

[design/multi_rate_tick_flag_timer.sv]
// Top level of the multi-rate tick flag timer: input register, step logic, result register.
`timescale 1ns / 1ps
// Each input transaction carries an op and a millisecond timestamp and yields exactly one
// result transaction with the sticky flags and the event pulses of that step. An item is
// registered on acceptance, processed by six parallel subtract-compare-reload counters once
// the result register is free or being read, and written to the result register, so a new
// item is taken every clock as long as the result side keeps up; the state update of the
// counters and flags, done in one step, sets that rate. Configuration writes
// are always accepted and are meant for times when no item is in flight; a period change
// takes effect at the next reload or preset.
module multi_rate_tick_flag_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // now_ms[31:0], clear_mask[38:32], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // flags[6:0], events[11:7], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mrt_pkg::*;

  logic     in_valid;
  item_t    in_item;
  logic     advance;
  period_t  period;
  logic [EVENT_W-1:0] event_enable;
  result_t  step_result;
  result_t  out_result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op         <= op_t'(s_tuser);
      in_item.now_ms     <= s_tdata[TIME_W-1:0];
      in_item.clear_mask <= s_tdata[TIME_W+FLAG_W-1:TIME_W];
    end
  end

  mrt_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .period       (period),
    .event_enable (event_enable)
  );

  mrt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (in_item),
    .period       (period),
    .event_enable (event_enable),
    .result       (step_result)
  );

  // hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {4'b0000, out_result.events, out_result.flags};

endmodule

[tb/tb_multi_rate_tick_flag_timer.sv]
// Self-checking testbench for the multi-rate tick flag timer with a scoreboard class.
`timescale 1ns / 1ps
module tb_multi_rate_tick_flag_timer;
  import mrt_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 150;

  // Tracks the timer state, predicts flags and events per item, and checks each result.
  class prescaler_scoreboard;
    period_t           period_reg;
    logic [4:0]        event_en;
    logic [TIME_W-1:0] last_ms;
    period_t           count_left;
    logic [6:0]        sticky;
    result_t           expected_results[$];
    int                errors;
    int                checked;

    function new();
      period_reg = PERIOD_RESET;
      count_left = PERIOD_RESET;
      event_en   = '0;
      last_ms    = '0;
      sticky     = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (reg_idx_t'(idx))
        REG_EVENT_ENABLE: event_en = data[4:0];
        REG_UNUSED: ;
        default: period_reg[idx] = data;
      endcase
    endfunction

    function void take_item(item_t it);
      logic [TIME_W-1:0] elapsed;
      result_t r;
      r.events = '0;
      case (it.op)
        OP_UPDATE: begin
          elapsed = it.now_ms - last_ms;
          if (elapsed != 0) sticky[0] = 1'b1;
          for (int i = 0; i < NUM_CNT; i++) begin
            // clamp at zero, fire once, reload
            if (elapsed > {16'd0, count_left[i]}) count_left[i] = '0;
            else count_left[i] = count_left[i] - elapsed[15:0];
            if (count_left[i] == 0) begin
              sticky[i+1] = 1'b1;
              count_left[i] = period_reg[i];
              if (i > 0 && event_en[i-1]) r.events[i-1] = 1'b1;
            end
          end
          last_ms = it.now_ms;
        end
        OP_CLEAR_MASK: sticky = sticky & ~it.clear_mask;
        OP_CLEAR_ALL: begin
          sticky = '0;
          count_left = period_reg;
        end
        default: last_ms = it.now_ms;
      endcase
      r.flags = sticky;
      expected_results.push_back(r);
    endfunction

    function void check_output(logic [6:0] flags, logic [4:0] events);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, flags=%h events=%h",
                 $time, flags, events);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (flags !== want.flags) begin
        $display("%0t ns: flags mismatch, expected %h, actual %h", $time, want.flags, flags);
        errors++;
      end
      if (events !== want.events) begin
        $display("%0t ns: events mismatch, expected %h, actual %h",
                 $time, want.events, events);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // now_ms[31:0], clear_mask[38:32], zero pad
  logic [1:0]  s_tuser;   // op[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // flags[6:0], events[11:7], zero pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  prescaler_scoreboard prescaler_sb;
  item_t               seen_item;
  logic [TIME_W-1:0]   clock_ms;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  items_taken;
  int                  cfg_writes;
  int                  settings_used;
  int                  stall_count;

  multi_rate_tick_flag_timer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: drop tready in random bursts while recv_idle_pct is nonzero.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Monitor all three channels and run the stall watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) prescaler_sb.check_output(m_tdata[6:0], m_tdata[11:7]);
      if (s_tvalid && s_tready) begin
        seen_item.op         = op_t'(s_tuser);
        seen_item.now_ms     = s_tdata[31:0];
        seen_item.clear_mask = s_tdata[38:32];
        prescaler_sb.take_item(seen_item);
        items_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        prescaler_sb.write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(input op_t op, input logic [31:0] now, input logic [6:0] mask);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, mask, now};
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold the sender until every expected result is in, then let the pipeline settle.
  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (prescaler_sb.expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input reg_idx_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input period_t per, input logic [15:0] en_word);
    for (int i = 0; i < NUM_CNT; i++) cfg_put(reg_idx_t'(i), per[i]);
    cfg_put(REG_EVENT_ENABLE, en_word);
    cfg_put(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] random_period();
    case ($urandom_range(9))
      0: random_period = 16'd0;
      1: random_period = 16'd1;
      2: random_period = 16'd65535;
      3, 4, 5, 6: random_period = 16'($urandom_range(20, 1));
      default: random_period = 16'($urandom_range(65535, 1));
    endcase
  endfunction

  function automatic logic [31:0] random_delta();
    int r;
    r = $urandom_range(99);
    if (r < 10) random_delta = 32'd0;
    else if (r < 60) random_delta = $urandom_range(8, 1);
    else if (r < 85) random_delta = $urandom_range(200, 1);
    else if (r < 95) random_delta = $urandom_range(70000, 1);
    else random_delta = $urandom;
  endfunction

  task automatic run_phase(input int idx, input bit last_phase);
    period_t     per;
    logic [15:0] en_word;
    int          r;
    case (idx)
      0: per = PERIOD_RESET;
      1: per = {NUM_CNT{16'd1}};
      2: per = {NUM_CNT{16'd65535}};
      default: for (int i = 0; i < NUM_CNT; i++) per[i] = random_period();
    endcase
    en_word = (idx == 1) ? 16'hFFFF : 16'($urandom);
    load_config(per, en_word);
    case (idx % 4)
      0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      1: begin send_idle_pct = 25; recv_idle_pct = 25; end
      2: begin send_idle_pct = 50; recv_idle_pct = 5;  end
      default: begin send_idle_pct = 5; recv_idle_pct = 50; end
    endcase
    if (last_phase) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (idx == 3 && n == PHASE_ITEMS / 2) wait_results();
      r = $urandom_range(99);
      if (r < 70) begin
        clock_ms = clock_ms + random_delta();
        push_item(OP_UPDATE, clock_ms, 7'($urandom));
      end else if (r < 78) begin
        // restart from the running clock or from anywhere
        clock_ms = $urandom_range(1) ? $urandom : clock_ms + random_delta();
        push_item(OP_START, clock_ms, 7'($urandom));
      end else if (r < 93) begin
        push_item(OP_CLEAR_MASK, $urandom, 7'($urandom));
      end else begin
        push_item(OP_CLEAR_ALL, $urandom, 7'($urandom));
      end
    end
    wait_results();
  endtask

  initial begin
    prescaler_sb  = new();
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    s_tuser       <= OP_UPDATE;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_PERIOD_5MS;
    cfg_data      <= '0;
    clock_ms      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_taken   = 0;
    cfg_writes    = 0;
    settings_used = 0;
    stall_count   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset periods, events disabled.
    push_item(OP_UPDATE, 32'd0, 7'h00);              // no time passed
    push_item(OP_UPDATE, 32'd4, 7'h7F);
    push_item(OP_UPDATE, 32'd5, 7'h00);              // fastest counter fires
    push_item(OP_START, 32'hFFFF_FFF0, 7'h00);
    push_item(OP_UPDATE, 32'h0000_0010, 7'h00);      // elapsed wraps around zero
    push_item(OP_UPDATE, 32'hFFFF_FFFF, 7'h00);      // huge gap fires each counter once
    push_item(OP_CLEAR_MASK, 32'hFFFF_FFFF, 7'h55);
    push_item(OP_CLEAR_MASK, 32'h0000_0000, 7'h2A);
    push_item(OP_UPDATE, 32'hFFFF_FFFF, 7'h00);      // zero elapsed
    push_item(OP_CLEAR_MASK, 32'h1234_5678, 7'h00);
    push_item(OP_CLEAR_ALL, 32'hA5A5_A5A5, 7'h7F);
    push_item(OP_START, 32'h8000_0000, 7'h00);
    push_item(OP_UPDATE, 32'h8000_EA60, 7'h00);      // exactly one minute
    wait_results();

    // Zero and tiny periods, all events on, high data bits set on the enable write.
    load_config({16'd65535, 16'd4, 16'd3, 16'd2, 16'd1, 16'd0}, 16'hFFFF);
    push_item(OP_CLEAR_ALL, 32'd0, 7'h00);
    push_item(OP_UPDATE, 32'h8000_EA60, 7'h00);      // zero period fires on zero elapsed
    push_item(OP_UPDATE, 32'h8000_EA61, 7'h00);
    push_item(OP_UPDATE, 32'h8000_EA63, 7'h00);
    push_item(OP_UPDATE, 32'h8001_EA62, 7'h00);
    push_item(OP_START, 32'h0000_0000, 7'h7F);
    push_item(OP_UPDATE, 32'h0000_0004, 7'h00);
    push_item(OP_CLEAR_MASK, 32'd0, 7'h7F);
    push_item(OP_UPDATE, 32'h0000_0004, 7'h00);
    wait_results();
    clock_ms = 32'h0000_0004;

    for (int p = 0; p < PHASES; p++) run_phase(p, p == PHASES - 1);

    repeat (10) @(posedge clk);
    $display("Covered %0d items and %0d results over %0d register settings (%0d writes).",
             items_taken, prescaler_sb.checked, settings_used, cfg_writes);
    $display("Mixed updates, starts, masked and full clears with random idling on both sides.");
    if (prescaler_sb.errors == 0 && prescaler_sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
